// ===== design/kspt_pkg.sv =====
// Shared types, codes and constants of the keyed sorted priority table.
`timescale 1ns / 1ps

package kspt_pkg;

	localparam int KSPT_CAPACITY = 32;

	localparam int KEY_HIGH_W   = 24;
	localparam int KEY_MIDDLE_W = 64;
	localparam int KEY_LOW_W    = 64;
	localparam int RANK_W       = 32;
	localparam int DATA_W       = KEY_HIGH_W + KEY_MIDDLE_W + KEY_LOW_W + RANK_W;

	// Command codes carried on the request side-band.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_DRAIN  = 2'd2;

	typedef enum logic [2:0] {
		ST_DRAINED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FULL      = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_DRAIN
	} fsm_state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_DRAIN
	} cell_op_t;

	typedef struct packed {
		logic signed [RANK_W-1:0] rank;
		logic [KEY_LOW_W-1:0]     key_low;
		logic [KEY_MIDDLE_W-1:0]  key_middle;
		logic [KEY_HIGH_W-1:0]    key_high;
	} entry_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		cell_op_t op;
		entry_t   entry;
	} cell_ctl_t;

endpackage

// ===== design/kspt_cell.sv =====
// One slot of the sorted table: holds an entry and moves it along the chain.
`timescale 1ns / 1ps

module kspt_cell import kspt_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occ,
	input  entry_t    prev_entry,
	input  logic      prev_stay,
	input  entry_t    next_entry,
	input  logic      del_in,
	output entry_t    entry,
	output logic      stay,
	output logic      del_out,
	output logic      match
);

	entry_t entry_q;

	assign entry = entry_q;

	assign match = occ &&
		(entry_q.key_high == ctl.entry.key_high) &&
		(entry_q.key_middle == ctl.entry.key_middle) &&
		(entry_q.key_low == ctl.entry.key_low);

	// An occupied slot whose rank is not above the new one keeps its place on insert.
	assign stay = occ && ($signed(entry_q.rank) <= $signed(ctl.entry.rank));

	// Every slot at or after the matching one pulls from its successor on remove.
	assign del_out = del_in | match;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (!stay) begin
					if (prev_stay) begin
						entry_q <= ctl.entry;
					end else begin
						entry_q <= prev_entry;
					end
				end
			end
			CELL_REMOVE: begin
				if (del_out) begin
					entry_q <= next_entry;
				end
			end
			CELL_DRAIN: begin
				entry_q <= next_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

// ===== design/keyed_sorted_priority_table.sv =====
// Top level of the keyed sorted priority table: controller, cell chain and output register.
`timescale 1ns / 1ps

// The table holds up to CAPACITY named entries kept in ascending rank order in a row of
// cells, one entry per cell, with entry 0 at the head. Each request carries a command on
// s_tuser and a name and rank on s_tdata. An insert of a name already present answers
// "duplicate" (even when the table is full); an insert into a full table answers "full"
// and changes nothing; otherwise the entry lands after every entry of equal or lower rank,
// so equal ranks leave in arrival order. A remove deletes the entry with that name or
// answers "not found". A drain streams every entry from the head, one per cycle while the
// output register is free, marks the final one with m_tlast and leaves the table empty;
// a drain of an empty table gives a single "empty" result. Command code 3 is ignored and
// gives no result. Every non-drain result carries zero data and m_tlast high. Each
// request is first captured; an insert or remove then waits for a free output register,
// and all cells compare the name and rank against the broadcast request and shift in
// parallel; the longest path is that compare plus the one-bit delete chain across cells.
// A new request is taken only once the previous one has placed its last result in the
// output register, which may still be waiting on m_tready.
module keyed_sorted_priority_table import kspt_pkg::*; #(
	parameter int CAPACITY = KSPT_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// Fields from bit 0 up: key_high[23:0], key_middle[63:0], key_low[63:0], rank[31:0].
	input  logic [DATA_W-1:0] s_tdata,
	// Fields from bit 0 up: cmd[1:0].
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// Fields from bit 0 up: out_key_high[23:0], out_key_middle[63:0], out_key_low[63:0],
	// out_rank[31:0].
	output logic [DATA_W-1:0] m_tdata,
	// Fields from bit 0 up: status[2:0].
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);

	fsm_state_t      state_q, state_d;
	logic [CW-1:0]   fill_count_q, fill_count_d;
	logic [1:0]      cmd_q;
	entry_t          req_q;

	logic            out_valid_q;
	entry_t          out_entry_q;
	status_t         out_status_q;
	logic            out_last_q;

	logic            load_out;
	entry_t          load_entry;
	status_t         load_status;
	logic            load_last;
	logic            take_req;
	cell_ctl_t       ctl;

	entry_t          cell_entry [CAPACITY];
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] stay;
	logic [CAPACITY-1:0] match;
	logic [CAPACITY:0]   del_chain;

	logic            out_free;
	logic            found;
	logic            full;

	assign out_free = !out_valid_q || m_tready;
	assign found    = |match;
	assign full     = (fill_count_q == CW'(CAPACITY));

	assign del_chain[0] = 1'b0;

	// The cell row. Cell 0 always sees an occupied, staying neighbor in front of it, and
	// the last cell pulls in an empty entry when the row shifts toward the head.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_s;

		assign occ[i] = (fill_count_q > CW'(i));

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_s = 1'b1;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_s = stay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		kspt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ[i]),
			.prev_entry (prev_e),
			.prev_stay  (prev_s),
			.next_entry (next_e),
			.del_in     (del_chain[i]),
			.entry      (cell_entry[i]),
			.stay       (stay[i]),
			.del_out    (del_chain[i+1]),
			.match      (match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			fill_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			fill_count_q <= fill_count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload registers need no reset.
	always_ff @(posedge clk) begin
		if (take_req) begin
			cmd_q            <= s_tuser;
			req_q.key_high   <= s_tdata[KEY_HIGH_W-1:0];
			req_q.key_middle <= s_tdata[KEY_HIGH_W+KEY_MIDDLE_W-1:KEY_HIGH_W];
			req_q.key_low    <= s_tdata[KEY_HIGH_W+KEY_MIDDLE_W+KEY_LOW_W-1:
				KEY_HIGH_W+KEY_MIDDLE_W];
			req_q.rank       <= s_tdata[DATA_W-1:DATA_W-RANK_W];
		end
		if (load_out) begin
			out_entry_q  <= load_entry;
			out_status_q <= load_status;
			out_last_q   <= load_last;
		end
	end

	always_comb begin
		state_d      = state_q;
		fill_count_d = fill_count_q;
		s_tready     = 1'b0;
		take_req     = 1'b0;
		load_out     = 1'b0;
		load_entry   = '0;
		load_status  = ST_EMPTY;
		load_last    = 1'b1;
		ctl.op       = CELL_HOLD;
		ctl.entry    = req_q;

		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					take_req = 1'b1;
					state_d  = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				case (cmd_q)
					CMD_INSERT: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = FSM_IDLE;
							if (found) begin
								load_status = ST_DUPLICATE;
							end else if (full) begin
								load_status = ST_FULL;
							end else begin
								load_status  = ST_INSERTED;
								ctl.op       = CELL_INSERT;
								fill_count_d = fill_count_q + CW'(1);
							end
						end
					end
					CMD_REMOVE: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = FSM_IDLE;
							if (found) begin
								load_status  = ST_REMOVED;
								ctl.op       = CELL_REMOVE;
								fill_count_d = fill_count_q - CW'(1);
							end else begin
								load_status = ST_NOT_FOUND;
							end
						end
					end
					CMD_DRAIN: begin
						if (fill_count_q != '0) begin
							state_d = FSM_DRAIN;
						end else if (out_free) begin
							load_out    = 1'b1;
							load_status = ST_EMPTY;
							state_d     = FSM_IDLE;
						end
					end
					default: begin
						state_d = FSM_IDLE;
					end
				endcase
			end
			FSM_DRAIN: begin
				if (out_free) begin
					load_out     = 1'b1;
					load_entry   = cell_entry[0];
					load_status  = ST_DRAINED;
					load_last    = (fill_count_q == CW'(1));
					ctl.op       = CELL_DRAIN;
					fill_count_d = fill_count_q - CW'(1);
					if (fill_count_q == CW'(1)) begin
						state_d = FSM_IDLE;
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_entry_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// The table never holds more entries than it has cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// Names are unique, so at most one cell can match a request.
	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_EXEC |-> $onehot0(match))
		else $error("more than one cell matches the request name");

	// Entries are sorted, so the cells that keep their place on insert form a run from the head.
	a_sorted_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_EXEC |-> ((stay + CAPACITY'(1)) & stay) == '0)
		else $error("cell order is not sorted by rank");

	// A drain in progress always has an entry left to send.
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DRAIN |-> fill_count_q != '0)
		else $error("draining an empty table");
`endif

endmodule
